FILE: design/tdcdf_pkg.sv
// Shared types and constants for the TDC event word deframer.
// Used by tdcdf_decode, the top level core and the port checker.
package tdcdf_pkg;

  // Largest event the readout may produce; the data word tally saturates at
  // this value or at the full tally range, whichever is smaller.
  localparam int unsigned MAX_EVENT_WORDS = 65535;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ID_W    = 12;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned KIND_W  = 3;

  // Bit position of the word type field
  localparam int unsigned TYPE_LSB = 28;
  localparam int unsigned EVT_LSB  = 12;

  localparam int unsigned TALLY_MAX_FULL = (1 << TALLY_W) - 1;
  localparam logic [TALLY_W-1:0] TALLY_LIMIT =
    (MAX_EVENT_WORDS > TALLY_MAX_FULL) ? TALLY_W'(TALLY_MAX_FULL)
                                       : TALLY_W'(MAX_EVENT_WORDS);

  // Readout word types
  localparam logic [TYPE_W-1:0] TYPE_HEADER  = 4'h0;
  localparam logic [TYPE_W-1:0] TYPE_TRAILER = 4'h1;
  localparam logic [TYPE_W-1:0] TYPE_DATA_A  = 4'h4;
  localparam logic [TYPE_W-1:0] TYPE_DATA_B  = 4'h5;
  localparam logic [TYPE_W-1:0] TYPE_DATA_C  = 4'h6;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OK         = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NO_TRAILER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MISMATCH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_HEADER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BAD_OR_END = 3'd5;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  data_word;
    logic [ID_W-1:0]    bunch_number;
    logic [ID_W-1:0]    event_number;
    logic [ID_W-1:0]    trailer_count;
    logic [TALLY_W-1:0] data_count;
  } out_beat_t;

  // Framing context carried from word to word
  typedef struct packed {
    logic               in_event;
    logic [ID_W-1:0]    held_bunch;
    logic [ID_W-1:0]    held_event;
    logic [TALLY_W-1:0] word_tally;
  } frame_ctx_t;

endpackage

FILE: design/tdcdf_decode.sv
// Word decoder for the TDC event word deframer: next framing context and
// the result beat for one readout word. Depends on tdcdf_pkg.
module tdcdf_decode (
  input  tdcdf_pkg::frame_ctx_t ctx,
  input  tdcdf_pkg::in_beat_t   beat,
  output tdcdf_pkg::frame_ctx_t ctx_nxt,
  output tdcdf_pkg::out_beat_t  res,
  output logic                  res_valid
);

  logic [tdcdf_pkg::TYPE_W-1:0] wtype;
  logic [tdcdf_pkg::ID_W-1:0]   w_lo;
  logic [tdcdf_pkg::ID_W-1:0]   w_evt;

  assign wtype = beat.word[tdcdf_pkg::TYPE_LSB +: tdcdf_pkg::TYPE_W];
  assign w_lo  = beat.word[tdcdf_pkg::ID_W-1:0];
  assign w_evt = beat.word[tdcdf_pkg::EVT_LSB +: tdcdf_pkg::ID_W];

  always_comb begin
    ctx_nxt   = ctx;
    res       = '0;
    res_valid = 1'b0;

    // open-event fields by default; zeroed below where no event is open
    res.bunch_number = ctx.held_bunch;
    res.event_number = ctx.held_event;
    res.data_count   = ctx.word_tally;

    if (beat.end_of_stream) begin
      // end of stream closes everything
      res_valid = 1'b1;
      res.kind  = tdcdf_pkg::KIND_BAD_OR_END;
      if (!ctx.in_event) begin
        res.bunch_number = '0;
        res.event_number = '0;
        res.data_count   = '0;
      end
      ctx_nxt.in_event = 1'b0;
    end else if (!ctx.in_event) begin
      // idle: only a header is expected
      if (wtype == tdcdf_pkg::TYPE_HEADER) begin
        ctx_nxt.in_event   = 1'b1;
        ctx_nxt.held_bunch = w_lo;
        ctx_nxt.held_event = w_evt;
        ctx_nxt.word_tally = '0;
      end else begin
        res_valid        = 1'b1;
        res.kind         = tdcdf_pkg::KIND_NOT_HEADER;
        res.bunch_number = '0;
        res.event_number = '0;
        res.data_count   = '0;
      end
    end else begin
      res_valid = 1'b1;
      unique case (wtype) inside
        tdcdf_pkg::TYPE_DATA_A, tdcdf_pkg::TYPE_DATA_B, tdcdf_pkg::TYPE_DATA_C: begin
          // saturating tally, result carries the new count
          if (ctx.word_tally < tdcdf_pkg::TALLY_LIMIT) begin
            ctx_nxt.word_tally = ctx.word_tally + 1'b1;
          end
          res.kind       = tdcdf_pkg::KIND_DATA;
          res.data_word  = beat.word;
          res.data_count = ctx_nxt.word_tally;
        end
        tdcdf_pkg::TYPE_TRAILER: begin
          res.kind          = (w_evt == ctx.held_event) ? tdcdf_pkg::KIND_OK
                                                        : tdcdf_pkg::KIND_MISMATCH;
          res.trailer_count = w_lo;
          ctx_nxt.in_event  = 1'b0;
        end
        tdcdf_pkg::TYPE_HEADER: begin
          // close the open event as unterminated, then open the next one
          res.kind           = tdcdf_pkg::KIND_NO_TRAILER;
          ctx_nxt.held_bunch = w_lo;
          ctx_nxt.held_event = w_evt;
          ctx_nxt.word_tally = '0;
        end
        default: begin
          res.kind         = tdcdf_pkg::KIND_BAD_OR_END;
          ctx_nxt.in_event = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/tdc_event_word_deframer_core.sv
// Top level of the TDC event word deframer: framing context registers and
// the result register. Depends on tdcdf_pkg and tdcdf_decode.
//
//  channel | ports                          | payload type
//  --------+--------------------------------+----------------------
//  input   | in_valid, in_stall, in_beat    | tdcdf_pkg::in_beat_t
//  result  | out_valid, out_stall, out_beat | tdcdf_pkg::out_beat_t
//
// One word per cycle while no stalled result blocks the input: each beat is
// decoded in the cycle it is accepted and its result, if any, shows in the
// result register on the next cycle. The result register is the only buffer;
// a new beat is taken whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) returns the framer to idle with empty output.
module tdc_event_word_deframer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tdcdf_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tdcdf_pkg::out_beat_t out_beat
);

  tdcdf_pkg::frame_ctx_t ctx_r;
  tdcdf_pkg::frame_ctx_t ctx_nxt;
  tdcdf_pkg::out_beat_t  res;
  tdcdf_pkg::out_beat_t  out_beat_r;
  logic                  res_valid;
  logic                  out_valid_r;
  logic                  in_acc;
  logic                  out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_acc   = in_valid && out_free;

  tdcdf_decode u_decode (
    .ctx       (ctx_r),
    .beat      (in_beat),
    .ctx_nxt   (ctx_nxt),
    .res       (res),
    .res_valid (res_valid)
  );

  // framing context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (in_acc) begin
      ctx_r <= ctx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: design/tdcdf_checker.sv
// Port-level checks for the TDC event word deframer, bound to the top level.
// Depends on tdcdf_pkg.
module tdcdf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input tdcdf_pkg::in_beat_t  in_beat,
  input logic                 out_valid,
  input logic                 out_stall,
  input tdcdf_pkg::out_beat_t out_beat
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed under stall");

  // end of stream always reports on the next cycle
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.end_of_stream |=>
      out_valid && out_beat.kind == tdcdf_pkg::KIND_BAD_OR_END)
    else $error("end of stream beat gave no end result");

  // a not-header error is raised with no event open
  a_not_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == tdcdf_pkg::KIND_NOT_HEADER |->
      out_beat.bunch_number == '0 && out_beat.event_number == '0 &&
      out_beat.data_count == '0)
    else $error("not-header result carries event fields");

  // a passed data word has been counted
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == tdcdf_pkg::KIND_DATA |->
      out_beat.data_count != '0 && out_beat.trailer_count == '0)
    else $error("data result with zero tally");

endmodule

bind tdc_event_word_deframer_core tdcdf_checker u_tdcdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
